// ===== src/greedy_graph_coloring_unit_assert.svh =====
// ----------------------------------------------------------------------------
// greedy_graph_coloring_unit assertion macros
// shared property wrappers for the coloring unit checkers
// ----------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_UNIT_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_UNIT_ASSERT_SVH

// checked only outside reset
`define GGC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ggc assertion failed");

// checked during reset as well
`define GGC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ggc reset assertion failed");

`endif

// ===== src/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggc_pkg
// shared constants and types of the greedy graph coloring unit
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned VTX_W            = 7;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_RUN  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } adj_ctl_t;

endpackage

// ===== src/greedy_graph_coloring_unit.sv =====
// An edge item is taken while the unit is idle and gives no result.
// A run item holds the input stalled while it colours N vertices; each vertex
// takes an adjacency read (ST_ADJ), a class scan (ST_SCAN) that tries classes in
// order until one fits or a new one opens, and an output step (ST_OUT) that waits while the output is stalled.
// Reset clears control state and all adjacency row valid flags at once;
// no clearing pass is needed and an item may be taken in the first cycle.
// ----------------------------------------------------------------------------
// greedy_graph_coloring_unit
// first-fit graph colouring over adjacency and class memories
// ----------------------------------------------------------------------------
module greedy_graph_coloring_unit #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [ggc_pkg::VTX_W-1:0]   vertex_a_i,
  input  logic [ggc_pkg::VTX_W-1:0]   vertex_b_i,
  input  logic [ggc_pkg::VTX_W-1:0]   vertex_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ggc_pkg::VTX_W-1:0]   vertex_index_o,
  output logic [ggc_pkg::VTX_W-1:0]   color_o,
  output logic                        last_o
);
  import ggc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [VTX_W-1:0] MaxV = VTX_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADJ,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     v_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     classes_q;
  logic [CW-1:0]     c_q;
  logic [CW-1:0]     color_q;
  logic              out_vld_q;
  logic [CW-1:0]     out_vertex_q;
  logic [CW-1:0]     out_color_q;
  logic              out_last_q;

  logic              accept;
  logic              is_run;
  logic              edge_ok;
  logic [VTX_W-1:0]  hi_v;
  logic [VTX_W-1:0]  lo_v;
  logic [CW-1:0]     n_sat;
  logic              out_free;
  logic              out_load;
  logic              run_done;
  logic              cls_avail;
  logic              cls_fit;
  logic              cls_new;
  logic [MAX_VERTICES-1:0] nbrs;
  logic [MAX_VERTICES-1:0] vbit;
  logic [MAX_VERTICES-1:0] cls_rdata;
  logic [MAX_VERTICES-1:0] cls_wdata;
  logic              cls_we;
  logic              cls_re;
  logic [AW-1:0]     cls_raddr;
  adj_ctl_t          adj_ctl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_run     = (opcode_i == OP_RUN);

  assign edge_ok = (vertex_a_i != '0) && (vertex_a_i <= MaxV) &&
                   (vertex_b_i != '0) && (vertex_b_i <= MaxV) &&
                   (vertex_a_i != vertex_b_i);

  // only earlier vertices matter, so an edge lands in the row of its higher end
  assign hi_v  = (vertex_a_i > vertex_b_i) ? vertex_a_i : vertex_b_i;
  assign lo_v  = (vertex_a_i > vertex_b_i) ? vertex_b_i : vertex_a_i;
  assign n_sat = (vertex_count_i > MaxV) ? CW'(MAX_VERTICES) : CW'(vertex_count_i);

  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = (state_q == ST_OUT) && out_free;
  assign run_done = out_load && (v_q == n_q);

  assign adj_ctl.wr_en = accept && !is_run && edge_ok;
  assign adj_ctl.rd_en = (state_q == ST_ADJ);
  assign adj_ctl.clear = (accept && is_run && (n_sat == '0)) || run_done;

  ggc_adj_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (adj_ctl),
    .waddr_i (AW'(hi_v - VTX_W'(1))),
    .wbit_i  (AW'(lo_v - VTX_W'(1))),
    .raddr_i (AW'(v_q - CW'(1))),
    .rdata_o (nbrs)
  );

  assign vbit      = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << AW'(v_q - CW'(1));
  assign cls_avail = (c_q < classes_q);
  assign cls_fit   = cls_avail && ((cls_rdata & nbrs) == '0);
  assign cls_new   = !cls_avail;
  assign cls_we    = (state_q == ST_SCAN) && (cls_fit || cls_new);
  assign cls_wdata = cls_new ? vbit : (cls_rdata | vbit);
  assign cls_re    = (state_q == ST_ADJ) || (state_q == ST_SCAN);
  assign cls_raddr = (state_q == ST_ADJ) ? '0 : AW'(c_q + CW'(1));

  ggc_cls_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_cls_mem (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (AW'(c_q)),
    .wdata_i (cls_wdata),
    .re_i    (cls_re),
    .raddr_i (cls_raddr),
    .rdata_o (cls_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      v_q          <= '0;
      n_q          <= '0;
      classes_q    <= '0;
      c_q          <= '0;
      color_q      <= '0;
      out_vld_q    <= 1'b0;
      out_vertex_q <= '0;
      out_color_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && is_run && (n_sat != '0)) begin
            v_q       <= CW'(1);
            n_q       <= n_sat;
            classes_q <= '0;
            state_q   <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          c_q     <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cls_fit || cls_new) begin
            color_q <= c_q + CW'(1);
            if (cls_new) begin
              classes_q <= classes_q + CW'(1);
            end
            state_q <= ST_OUT;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_vertex_q <= v_q;
            out_color_q  <= color_q;
            out_last_q   <= (v_q == n_q);
            if (v_q == n_q) begin
              state_q <= ST_IDLE;
            end else begin
              v_q     <= v_q + CW'(1);
              state_q <= ST_ADJ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign vertex_index_o = VTX_W'(out_vertex_q);
  assign color_o        = VTX_W'(out_color_q);
  assign last_o         = out_last_q;

endmodule

// ===== src/ggc_adj_mem.sv =====
// ----------------------------------------------------------------------------
// ggc_adj_mem
// adjacency row memory with bit-masked writes and per-row valid flags
// ----------------------------------------------------------------------------
module ggc_adj_mem #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ggc_pkg::adj_ctl_t               ctl_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] waddr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] wbit_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] raddr_i,
  output logic [MAX_VERTICES-1:0]         rdata_o
);
  import ggc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] rd_data_q;
  logic                    rd_vld_q;

  // an invalid row is rewritten whole, a valid one only at the new bit
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (!row_vld_q[waddr_i] || (wbit_i == AW'(i))) begin
          mem_q[waddr_i][i] <= (wbit_i == AW'(i));
        end
      end
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        row_vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= row_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== src/ggc_cls_mem.sv =====
// ----------------------------------------------------------------------------
// ggc_cls_mem
// colour class membership memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ggc_cls_mem #(
  parameter int unsigned MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] waddr_i,
  input  logic [MAX_VERTICES-1:0]         wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] raddr_i,
  output logic [MAX_VERTICES-1:0]         rdata_o
);
  import ggc_pkg::*;

  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_data_q;

endmodule

// ===== src/ggc_checker.sv =====
// ----------------------------------------------------------------------------
// ggc_checker
// port-level checks of the greedy graph coloring unit
// ----------------------------------------------------------------------------
`include "greedy_graph_coloring_unit_assert.svh"

module ggc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      opcode_i,
  input logic [ggc_pkg::VTX_W-1:0] vertex_a_i,
  input logic [ggc_pkg::VTX_W-1:0] vertex_b_i,
  input logic [ggc_pkg::VTX_W-1:0] vertex_count_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ggc_pkg::VTX_W-1:0] vertex_index_o,
  input logic [ggc_pkg::VTX_W-1:0] color_o,
  input logic                      last_o
);
  import ggc_pkg::*;

  `GGC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o)

  `GGC_ASSERT(a_run_busy, (in_valid_i && !in_stall_o && opcode_i && |vertex_count_i) |=> in_stall_o)

  `GGC_ASSERT(a_color_bound, out_valid_o |-> ((color_o != '0) && (color_o <= vertex_index_o)))

  `GGC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind greedy_graph_coloring_unit ggc_checker u_ggc_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for greedy_graph_coloring_unit. Conflict graphs
// are loaded edge by edge, then colouring runs are started. An in-bench
// first-fit predictor builds the expected vertex and colour stream, and each
// output item is compared against it. Directed corner cases come first, then
// random graphs under several idle and stall mixes, including a long output
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ggc_pkg::*;

  localparam int VW          = VTX_W;
  localparam int NV          = MAX_VERTICES_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] colour;
    logic          last;
  } colour_t;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_stall_o;
  logic          opcode_i       = 1'b0;
  logic [VW-1:0] vertex_a_i     = '0;
  logic [VW-1:0] vertex_b_i     = '0;
  logic [VW-1:0] vertex_count_i = '0;
  logic          out_valid_o;
  logic          out_stall_i    = 1'b0;
  logic [VW-1:0] vertex_index_o;
  logic [VW-1:0] color_o;
  logic          last_o;

  logic [NV-1:0] adj_rows [NV] = '{default: '0};
  colour_t       pending_colours [$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_seq     = 0;
  int hold_taken   = 0;
  int hold_left    = 0;
  int mismatches   = 0;
  int useful_items = 0;
  int cycle_count  = 0;

  greedy_graph_coloring_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_count_i (vertex_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_o (vertex_index_o),
    .color_o        (color_o),
    .last_o         (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
    end
  endtask

  function automatic void predict_item(opcode_e op, logic [VW-1:0] a, logic [VW-1:0] b,
                                       logic [VW-1:0] n);
    logic [NV-1:0] members [NV];
    logic [NV-1:0] nbrs;
    int            open_cnt;
    int            chosen;
    int            nn;
    colour_t       res;
    if (op == OP_EDGE) begin
      if (a >= 1 && a <= NV && b >= 1 && b <= NV && a != b) begin
        adj_rows[a-1][b-1] = 1'b1;
        adj_rows[b-1][a-1] = 1'b1;
      end
    end else begin
      nn = (n > NV) ? NV : int'(n);
      open_cnt = 0;
      for (int c = 0; c < NV; c++) members[c] = '0;
      for (int v = 1; v <= nn; v++) begin
        nbrs   = adj_rows[v-1];
        chosen = open_cnt;
        for (int c = 0; c < open_cnt; c++) begin
          if ((members[c] & nbrs) == '0) begin
            chosen = c;
            break;
          end
        end
        if (chosen == open_cnt && open_cnt < NV) open_cnt++;
        if (chosen >= NV) chosen = NV - 1;
        members[chosen][v-1] = 1'b1;
        res.vertex = VW'(v);
        res.colour = VW'(chosen + 1);
        res.last   = (v == nn);
        pending_colours.push_back(res);
      end
      for (int r = 0; r < NV; r++) adj_rows[r] = '0;
    end
  endfunction

  // receiver side: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_taken != hold_seq) begin
      hold_taken = hold_seq;
      hold_left  = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    colour_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colours.size() == 0) begin
        report_mismatch("unexpected item, vertex", int'(vertex_index_o), 0);
      end else begin
        want = pending_colours.pop_front();
        if (vertex_index_o !== want.vertex)
          report_mismatch("vertex_index", int'(vertex_index_o), int'(want.vertex));
        if (color_o !== want.colour)
          report_mismatch("color", int'(color_o), int'(want.colour));
        if (last_o !== want.last)
          report_mismatch("last", int'(last_o), int'(want.last));
      end
    end
  end

  task automatic send_item(opcode_e op, int a, int b, int n);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    vertex_a_i     <= VW'(a);
    vertex_b_i     <= VW'(b);
    vertex_count_i <= VW'(n);
    do @(posedge clk_i); while (in_stall_o);
    predict_item(op, VW'(a), VW'(b), VW'(n));
    if (op == OP_RUN || (a >= 1 && a <= NV && b >= 1 && b <= NV && a != b))
      useful_items++;
  endtask

  task automatic load_edge(int a, int b);
    send_item(OP_EDGE, a, b, int'($urandom_range(0, 127)));
  endtask

  task automatic colour_graph(int n);
    send_item(OP_RUN, int'($urandom_range(0, 127)), int'($urandom_range(0, 127)), n);
  endtask

  task automatic wait_for_colours();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_cases();
    send_item(OP_EDGE, 1, 2, 0);
    send_item(OP_EDGE, 2, 3, 127);
    load_edge(3, 1);
    load_edge(2, 2);
    load_edge(0, 3);
    load_edge(65, 1);
    load_edge(127, 127);
    load_edge(64, 0);
    load_edge(2, 1);
    load_edge(3, 4);
    send_item(OP_RUN, 127, 0, 3);
    load_edge(1, 2);
    send_item(OP_RUN, 0, 127, 0);
    colour_graph(2);
    load_edge(64, 1);
    load_edge(63, 64);
    load_edge(1, 63);
    colour_graph(127);
    colour_graph(64);
    colour_graph(1);
  endtask

  task automatic test_random_graphs(int send_idle, int recv_stall, int goal);
    int start;
    int n;
    int m;
    int k;
    int a;
    int b;
    int pick;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    start     = useful_items;
    while (useful_items - start < goal) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(33, NV) : $urandom_range(1, 12);
      // dense corner now and then to open many classes
      if ($urandom_range(4) == 0) begin
        k = (n < 8) ? n : $urandom_range(2, 8);
        for (int i = 1; i <= k; i++)
          for (int j = i + 1; j <= k; j++)
            if ($urandom_range(1)) load_edge(i, j);
            else load_edge(j, i);
      end
      m = $urandom_range(0, (2 * n > 30) ? 30 : 2 * n);
      for (int e = 0; e < m; e++) begin
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(0, 127);
          b = $urandom_range(0, 127);
        end else begin
          a = $urandom_range(1, (n + 2 > NV) ? NV : n + 2);
          b = $urandom_range(1, (n + 2 > NV) ? NV : n + 2);
        end
        load_edge(a, b);
      end
      pick = $urandom_range(99);
      if (pick < 80) colour_graph(n);
      else if (pick < 90) colour_graph(int'($urandom_range(0, n)));
      else if (pick < 95) colour_graph(int'($urandom_range(NV + 1, 127)));
      else colour_graph(0);
    end
  endtask

  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    wait_for_colours();
    for (int i = 1; i < 40; i++) load_edge(i, i + 1);
    hold_seq++;
    colour_graph(48);
    for (int i = 0; i < 6; i++)
      load_edge(int'($urandom_range(1, NV)), int'($urandom_range(1, NV)));
    colour_graph(NV);
    wait_for_colours();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_pct  = 26;
    stall_pct = 80;
    test_edge_cases();
    test_random_graphs(26, 80, 100);
    test_output_hold();
    test_random_graphs(80, 26, 100);
    test_random_graphs(0, 0, 100);
    wait_for_colours();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
